>>> rtl/ppp_pkg.sv
// ============================================================================
// Perspective point projection package
// Shared widths, constants and types of the projection pipeline.
// ============================================================================
package ppp_pkg;

    // Ratio divider: dividend is |coordinate| * min(W, H), 77 bits.
    localparam int P_W       = 77;
    localparam int DEN_W     = 49;
    localparam int Q_W       = 46;
    localparam int LOW_W     = 37;
    localparam int DIV_STEPS = 46;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    localparam int MAX_SHIFT = 18;

    localparam logic [17:0]    PI_Q16    = 18'd205887;
    localparam logic [Q_W-1:0] RATIO_CAP = 46'h2000_0000_0000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CAM_POS_X  = 3'd0;
    localparam logic [2:0] CFG_CAM_POS_Y  = 3'd1;
    localparam logic [2:0] CFG_CAM_POS_Z  = 3'd2;
    localparam logic [2:0] CFG_VIEW_DIR_X = 3'd3;
    localparam logic [2:0] CFG_VIEW_DIR_Y = 3'd4;
    localparam logic [2:0] CFG_VIEW_DIR_Z = 3'd5;
    localparam logic [2:0] CFG_SCREEN_W   = 3'd6;
    localparam logic [2:0] CFG_SCREEN_H   = 3'd7;

    // Basis sequencer operations, in the order they run.
    localparam logic [2:0] OP_RX = 3'd0;
    localparam logic [2:0] OP_RY = 3'd1;
    localparam logic [2:0] OP_UX = 3'd2;
    localparam logic [2:0] OP_UY = 3'd3;
    localparam logic [2:0] OP_UZ = 3'd4;

    localparam logic [5:0] ROOT_LAST = 6'd30;
    localparam logic [5:0] DIV_LAST  = 6'd63;

    typedef enum logic [2:0] {
        BS_READY,
        BS_SQUARE,
        BS_ROOT,
        BS_LOAD,
        BS_DIVIDE
    } bstate_t;

    typedef struct packed {
        logic vld;
        logic behind;
        logic neg_x;
        logic neg_y;
    } side_t;

endpackage

>>> rtl/ppp_div_pipe.sv
// ============================================================================
// Projection ratio divider
// Pipelined restoring divider, one quotient bit per stage, result capped.
// ============================================================================
module ppp_div_pipe (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ppp_pkg::P_W-1:0]     num,
    input  logic [ppp_pkg::DEN_W-1:0]   den,
    output logic [ppp_pkg::Q_W-1:0]     quo
);

    localparam int HI_W = ppp_pkg::P_W - ppp_pkg::LOW_W;

    logic [ppp_pkg::DEN_W-1:0] rem_reg  [0:ppp_pkg::DIV_STEPS];
    logic [ppp_pkg::LOW_W-1:0] low_reg  [0:ppp_pkg::DIV_STEPS];
    logic [ppp_pkg::Q_W-1:0]   quo_reg  [0:ppp_pkg::DIV_STEPS];
    logic [ppp_pkg::DEN_W-1:0] den_reg  [0:ppp_pkg::DIV_STEPS];
    logic                      over_reg [0:ppp_pkg::DIV_STEPS];

    logic [ppp_pkg::DEN_W:0]   trial    [0:ppp_pkg::DIV_STEPS-1];
    logic [ppp_pkg::DEN_W:0]   diff     [0:ppp_pkg::DIV_STEPS-1];
    logic                      fits     [0:ppp_pkg::DIV_STEPS-1];
    logic [HI_W-1:0]           num_hi;

    assign num_hi = num[ppp_pkg::P_W-1:ppp_pkg::LOW_W];

    always_comb begin
        for (int k = 0; k < ppp_pkg::DIV_STEPS; k++) begin
            trial[k] = {rem_reg[k], low_reg[k][ppp_pkg::LOW_W-1]};
            diff[k]  = trial[k] - {1'b0, den_reg[k]};
            fits[k]  = (trial[k] >= {1'b0, den_reg[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {{(ppp_pkg::DEN_W-HI_W){1'b0}}, num_hi};
            low_reg[0]  <= num[ppp_pkg::LOW_W-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            over_reg[0] <= ({{(ppp_pkg::DEN_W-HI_W){1'b0}}, num_hi} >= den);
            for (int k = 0; k < ppp_pkg::DIV_STEPS; k++) begin
                rem_reg[k+1]  <= fits[k] ? diff[k][ppp_pkg::DEN_W-1:0]
                                         : trial[k][ppp_pkg::DEN_W-1:0];
                low_reg[k+1]  <= {low_reg[k][ppp_pkg::LOW_W-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][ppp_pkg::Q_W-2:0], fits[k]};
                den_reg[k+1]  <= den_reg[k];
                over_reg[k+1] <= over_reg[k];
            end
        end
    end

    assign quo = (over_reg[ppp_pkg::DIV_STEPS] ||
                  quo_reg[ppp_pkg::DIV_STEPS][ppp_pkg::Q_W-1]) ?
                 ppp_pkg::RATIO_CAP : quo_reg[ppp_pkg::DIV_STEPS];

endmodule

>>> rtl/perspective_point_projection_unit.sv
// ============================================================================
// Perspective point projection unit
// One item per cycle is accepted while the output is not stalled and the
// camera basis is ready; items pass through the ratio divider pipeline.
// After reset and after every configuration write the camera basis is
// rebuilt by a serial root and divide sequencer, and s_ready stays low until it is done.
// Reset is synchronous, active low, and restores the default camera.
// ============================================================================
module perspective_point_projection_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [47:0]        s_point_x,
    input  logic [47:0]        s_point_y,
    input  logic [47:0]        s_point_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_screen_x,
    output logic [31:0]        m_screen_y,
    output logic               m_behind,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);

    // Configuration registers.
    logic signed [47:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [13:0]        scr_w_reg, scr_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= 48'sd65536;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            dir_x_reg <= 18'sh30000;
            dir_y_reg <= '0;
            dir_z_reg <= '0;
            scr_w_reg <= 14'd800;
            scr_h_reg <= 14'd600;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ppp_pkg::CFG_CAM_POS_X:  cam_x_reg <= cfg_data;
                ppp_pkg::CFG_CAM_POS_Y:  cam_y_reg <= cfg_data;
                ppp_pkg::CFG_CAM_POS_Z:  cam_z_reg <= cfg_data;
                ppp_pkg::CFG_VIEW_DIR_X: dir_x_reg <= cfg_data[17:0];
                ppp_pkg::CFG_VIEW_DIR_Y: dir_y_reg <= cfg_data[17:0];
                ppp_pkg::CFG_VIEW_DIR_Z: dir_z_reg <= cfg_data[17:0];
                ppp_pkg::CFG_SCREEN_W:   scr_w_reg <= cfg_data[13:0];
                ppp_pkg::CFG_SCREEN_H:   scr_h_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Basis sequencer
    // ------------------------------------------------------------------
    ppp_pkg::bstate_t state_reg, state_next;
    logic [35:0]        l2_reg, l2_next;
    logic [61:0]        rad_reg, rad_next;
    logic [32:0]        root_rem_reg, root_rem_next;
    logic [30:0]        root_res_reg, root_res_next;
    logic               root_sel_reg, root_sel_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [30:0]        hq_reg, hq_next;
    logic [30:0]        lq_reg, lq_next;
    logic [63:0]        num_reg, num_next;
    logic [30:0]        den_reg, den_next;
    logic [30:0]        drem_reg, drem_next;
    logic               neg_reg, neg_next;
    logic [2:0]         sel_reg, sel_next;
    logic signed [31:0] rx_reg, rx_next, ry_reg, ry_next;
    logic signed [31:0] ux_reg, ux_next, uy_reg, uy_next, uz_reg, uz_next;

    logic signed [35:0] sq_x, sq_y, sq_z;
    logic [35:0]        sq_h;
    logic [34:0]        r_trial, r_cand, r_diff;
    logic               r_fit;
    logic [31:0]        d_trial, d_diff;
    logic               d_fit;
    logic [63:0]        d_quo;
    logic [31:0]        q_abs, q_signed;
    logic [17:0]        dx_mag, dy_mag, dz_mag;
    logic [31:0]        rx_mag, ry_mag, mul_a;
    logic [49:0]        mul_p;
    logic [63:0]        load_num;
    logic               load_neg;

    assign sq_x = dir_x_reg * dir_x_reg;
    assign sq_y = dir_y_reg * dir_y_reg;
    assign sq_z = dir_z_reg * dir_z_reg;
    assign sq_h = sq_x + sq_y;

    assign r_trial = {root_rem_reg, rad_reg[61:60]};
    assign r_cand  = {2'b00, root_res_reg, 2'b01};
    assign r_fit   = (r_trial >= r_cand);
    assign r_diff  = r_trial - r_cand;

    assign d_trial = {drem_reg, num_reg[63]};
    assign d_fit   = (d_trial >= {1'b0, den_reg});
    assign d_diff  = d_trial - {1'b0, den_reg};
    assign d_quo   = {num_reg[62:0], d_fit};
    assign q_abs   = d_quo[31:0];
    assign q_signed = neg_reg ? (~q_abs + 32'd1) : q_abs;

    assign dx_mag = dir_x_reg[17] ? (~dir_x_reg + 18'd1) : dir_x_reg;
    assign dy_mag = dir_y_reg[17] ? (~dir_y_reg + 18'd1) : dir_y_reg;
    assign dz_mag = dir_z_reg[17] ? (~dir_z_reg + 18'd1) : dir_z_reg;
    assign rx_mag = rx_reg[31] ? (~rx_reg + 32'd1) : rx_reg;
    assign ry_mag = ry_reg[31] ? (~ry_reg + 32'd1) : ry_reg;
    assign mul_a  = (sel_reg == ppp_pkg::OP_UX) ? ry_mag : rx_mag;
    assign mul_p  = mul_a * dz_mag;

    always_comb begin
        load_num = '0;
        load_neg = 1'b0;
        unique case (sel_reg) inside
            ppp_pkg::OP_RX: begin
                load_num = {4'b0, dy_mag, 42'b0};
                load_neg = dir_y_reg[17];
            end
            ppp_pkg::OP_RY: begin
                load_num = {4'b0, dx_mag, 42'b0};
                load_neg = !dir_x_reg[17] && (dir_x_reg != '0);
            end
            ppp_pkg::OP_UX: begin
                load_num = {2'b0, mul_p, 12'b0};
                load_neg = ry_reg[31] ^ dir_z_reg[17];
            end
            ppp_pkg::OP_UY: begin
                load_num = {2'b0, mul_p, 12'b0};
                load_neg = !(rx_reg[31] ^ dir_z_reg[17]);
            end
            ppp_pkg::OP_UZ: begin
                load_num = {3'b0, hq_reg, 30'b0};
                load_neg = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        l2_next       = l2_reg;
        rad_next      = rad_reg;
        root_rem_next = root_rem_reg;
        root_res_next = root_res_reg;
        root_sel_next = root_sel_reg;
        cnt_next      = cnt_reg;
        hq_next       = hq_reg;
        lq_next       = lq_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        drem_next     = drem_reg;
        neg_next      = neg_reg;
        sel_next      = sel_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        ux_next       = ux_reg;
        uy_next       = uy_reg;
        uz_next       = uz_reg;
        unique case (state_reg)
            ppp_pkg::BS_READY: ;
            ppp_pkg::BS_SQUARE: begin
                l2_next       = sq_h + sq_z;
                rad_next      = {2'b00, sq_h, 24'b0};
                root_rem_next = '0;
                root_res_next = '0;
                root_sel_next = 1'b0;
                cnt_next      = '0;
                state_next    = ppp_pkg::BS_ROOT;
            end
            ppp_pkg::BS_ROOT: begin
                rad_next      = {rad_reg[59:0], 2'b00};
                root_rem_next = r_fit ? r_diff[32:0] : r_trial[32:0];
                root_res_next = {root_res_reg[29:0], r_fit};
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == ppp_pkg::ROOT_LAST) begin
                    cnt_next      = '0;
                    root_rem_next = '0;
                    root_res_next = '0;
                    if (!root_sel_reg) begin
                        hq_next       = {root_res_reg[29:0], r_fit};
                        rad_next      = {2'b00, l2_reg, 24'b0};
                        root_sel_next = 1'b1;
                    end else begin
                        lq_next    = {root_res_reg[29:0], r_fit};
                        sel_next   = ppp_pkg::OP_RX;
                        state_next = ppp_pkg::BS_LOAD;
                    end
                end
            end
            ppp_pkg::BS_LOAD: begin
                num_next   = load_num;
                den_next   = (sel_reg == ppp_pkg::OP_RX || sel_reg == ppp_pkg::OP_RY) ?
                             hq_reg : lq_reg;
                neg_next   = load_neg;
                drem_next  = '0;
                cnt_next   = '0;
                state_next = ppp_pkg::BS_DIVIDE;
            end
            ppp_pkg::BS_DIVIDE: begin
                num_next  = d_quo;
                drem_next = d_fit ? d_diff[30:0] : d_trial[30:0];
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == ppp_pkg::DIV_LAST) begin
                    unique case (sel_reg)
                        ppp_pkg::OP_RX: rx_next = q_signed;
                        ppp_pkg::OP_RY: ry_next = q_signed;
                        ppp_pkg::OP_UX: ux_next = q_signed;
                        ppp_pkg::OP_UY: uy_next = q_signed;
                        default:        uz_next = q_signed;
                    endcase
                    if (sel_reg == ppp_pkg::OP_UZ) begin
                        state_next = ppp_pkg::BS_READY;
                    end else begin
                        sel_next   = sel_reg + 3'd1;
                        state_next = ppp_pkg::BS_LOAD;
                    end
                end
            end
            default: state_next = ppp_pkg::BS_SQUARE;
        endcase
        if (cfg_valid) begin
            state_next = ppp_pkg::BS_SQUARE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppp_pkg::BS_SQUARE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        l2_reg       <= l2_next;
        rad_reg      <= rad_next;
        root_rem_reg <= root_rem_next;
        root_res_reg <= root_res_next;
        root_sel_reg <= root_sel_next;
        cnt_reg      <= cnt_next;
        hq_reg       <= hq_next;
        lq_reg       <= lq_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        drem_reg     <= drem_next;
        neg_reg      <= neg_next;
        sel_reg      <= sel_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        ux_reg       <= ux_next;
        uy_reg       <= uy_next;
        uz_reg       <= uz_next;
    end

    // ------------------------------------------------------------------
    // Item pipeline
    // ------------------------------------------------------------------
    logic en;
    logic m_valid_reg;
    logic degen;
    logic [13:0] hw;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en && (state_reg == ppp_pkg::BS_READY);
    assign degen   = (dir_x_reg == '0) && (dir_y_reg == '0);
    assign hw      = (scr_w_reg < scr_h_reg) ? scr_w_reg : scr_h_reg;

    // Stage 1: view vector.
    logic               vld1_reg;
    logic signed [48:0] vx1_reg, vy1_reg, vz1_reg;
    // Stage 2: largest magnitude.
    logic               vld2_reg;
    logic signed [48:0] vx2_reg, vy2_reg, vz2_reg;
    logic [48:0]        m2_reg;
    logic [48:0]        mag_x1, mag_y1, mag_z1, mag_xy1;
    // Stage 3: shift amount.
    logic               vld3_reg;
    logic signed [48:0] vx3_reg, vy3_reg, vz3_reg;
    logic [4:0]         s3_reg;
    logic [4:0]         shift_sel;
    // Stage 4: scaled vector.
    logic               vld4_reg;
    logic signed [31:0] vx4_reg, vy4_reg, vz4_reg;
    logic signed [48:0] sh_x, sh_y, sh_z;
    // Stage 5: products.
    logic               vld5_reg;
    logic signed [49:0] zx5_reg, zy5_reg, zz5_reg;
    logic signed [63:0] xx5_reg, xy5_reg, yx5_reg, yy5_reg, yz5_reg;
    logic signed [49:0] p_zx, p_zy, p_zz;
    logic signed [63:0] p_xx, p_xy, p_yx, p_yy, p_yz;
    // Stage 6: dot products.
    logic               vld6_reg;
    logic [51:0]        z6_reg;
    logic [63:0]        x6_reg, y6_reg;
    // Stage 7: magnitudes and flags.
    ppp_pkg::side_t     side7_reg, side8_reg, side9_reg, side_a_reg;
    logic [62:0]        magx7_reg, magy7_reg;
    logic [48:0]        d7_reg, d8_reg, d9_reg;
    logic [63:0]        abs_x6, abs_y6;
    logic               z_pos;
    // Stage 8: partial products.
    logic [45:0]        plx8_reg, ply8_reg;
    logic [44:0]        phx8_reg, phy8_reg;
    logic [45:0]        p_lx, p_ly;
    logic [44:0]        p_hx, p_hy;
    // Stage 9: dividends.
    logic [ppp_pkg::P_W-1:0] px9_reg, py9_reg;
    // Divider side data.
    ppp_pkg::side_t     sd_reg [0:ppp_pkg::DIV_LAT-1];
    logic [ppp_pkg::Q_W-1:0] ratio_x, ratio_y;
    // Stage A: scale by pi.
    logic [63:0]        prx_a_reg, pry_a_reg;
    logic [63:0]        p_pix, p_piy;
    // Stage B: centre, saturate, output.
    logic [63:0]        rnd_x, rnd_y;
    logic [32:0]        off_x, off_y;
    logic [34:0]        soff_x, soff_y, cen_x, cen_y, sum_x, sum_y;
    logic [31:0]        sat_x, sat_y, sent_x, sent_y;
    logic [31:0]        m_x_reg, m_y_reg;
    logic               m_behind_reg;

    assign mag_x1  = vx1_reg[48] ? (~vx1_reg + 49'd1) : vx1_reg;
    assign mag_y1  = vy1_reg[48] ? (~vy1_reg + 49'd1) : vy1_reg;
    assign mag_z1  = vz1_reg[48] ? (~vz1_reg + 49'd1) : vz1_reg;
    assign mag_xy1 = (mag_x1 > mag_y1) ? mag_x1 : mag_y1;

    always_comb begin
        shift_sel = '0;
        for (int i = ppp_pkg::MAX_SHIFT; i >= 0; i--) begin
            if ((m2_reg >> i) <= 49'h0_4000_0000) begin
                shift_sel = 5'(i);
            end
        end
    end

    assign sh_x = vx3_reg >>> s3_reg;
    assign sh_y = vy3_reg >>> s3_reg;
    assign sh_z = vz3_reg >>> s3_reg;

    assign p_zx = vx4_reg * dir_x_reg;
    assign p_zy = vy4_reg * dir_y_reg;
    assign p_zz = vz4_reg * dir_z_reg;
    assign p_xx = vx4_reg * rx_reg;
    assign p_xy = vy4_reg * ry_reg;
    assign p_yx = vx4_reg * ux_reg;
    assign p_yy = vy4_reg * uy_reg;
    assign p_yz = vz4_reg * uz_reg;

    assign abs_x6 = x6_reg[63] ? (~x6_reg + 64'd1) : x6_reg;
    assign abs_y6 = y6_reg[63] ? (~y6_reg + 64'd1) : y6_reg;
    assign z_pos  = !z6_reg[51] && (z6_reg != '0);

    assign p_lx = magx7_reg[31:0] * hw;
    assign p_hx = magx7_reg[62:32] * hw;
    assign p_ly = magy7_reg[31:0] * hw;
    assign p_hy = magy7_reg[62:32] * hw;

    ppp_div_pipe u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (px9_reg),
        .den  (d9_reg),
        .quo  (ratio_x)
    );

    ppp_div_pipe u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (py9_reg),
        .den  (d9_reg),
        .quo  (ratio_y)
    );

    assign p_pix = {18'b0, ratio_x} * {46'b0, ppp_pkg::PI_Q16};
    assign p_piy = {18'b0, ratio_y} * {46'b0, ppp_pkg::PI_Q16};

    assign rnd_x  = prx_a_reg + 64'h0000_0000_4000_0000;
    assign rnd_y  = pry_a_reg + 64'h0000_0000_4000_0000;
    assign off_x  = rnd_x[63:31];
    assign off_y  = rnd_y[63:31];
    assign soff_x = side_a_reg.neg_x ? (~{2'b00, off_x} + 35'd1) : {2'b00, off_x};
    assign soff_y = side_a_reg.neg_y ? (~{2'b00, off_y} + 35'd1) : {2'b00, off_y};
    assign cen_x  = {14'b0, scr_w_reg, 7'b0};
    assign cen_y  = {14'b0, scr_h_reg, 7'b0};
    assign sum_x  = cen_x + soff_x;
    assign sum_y  = cen_y - soff_y;
    assign sat_x  = (sum_x[34:31] == 4'b0000 || sum_x[34:31] == 4'b1111) ? sum_x[31:0] :
                    (sum_x[34] ? 32'h8000_0000 : 32'h7fff_ffff);
    assign sat_y  = (sum_y[34:31] == 4'b0000 || sum_y[34:31] == 4'b1111) ? sum_y[31:0] :
                    (sum_y[34] ? 32'h8000_0000 : 32'h7fff_ffff);
    assign sent_x = {7'b0, scr_w_reg, 11'b0} + {9'b0, scr_w_reg, 9'b0};
    assign sent_y = {7'b0, scr_h_reg, 11'b0} + {9'b0, scr_h_reg, 9'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            vld5_reg    <= 1'b0;
            vld6_reg    <= 1'b0;
            side7_reg   <= '0;
            side8_reg   <= '0;
            side9_reg   <= '0;
            for (int k = 0; k < ppp_pkg::DIV_LAT; k++) begin
                sd_reg[k] <= '0;
            end
            side_a_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld1_reg  <= s_valid && s_ready;
            vld2_reg  <= vld1_reg;
            vld3_reg  <= vld2_reg;
            vld4_reg  <= vld3_reg;
            vld5_reg  <= vld4_reg;
            vld6_reg  <= vld5_reg;
            side7_reg <= '{vld: vld6_reg, behind: degen || !z_pos,
                           neg_x: x6_reg[63], neg_y: y6_reg[63]};
            side8_reg <= side7_reg;
            side9_reg <= side8_reg;
            sd_reg[0] <= side9_reg;
            for (int k = 1; k < ppp_pkg::DIV_LAT; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
            side_a_reg  <= sd_reg[ppp_pkg::DIV_LAT-1];
            m_valid_reg <= side_a_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx1_reg <= {s_point_x[47], s_point_x} - {cam_x_reg[47], cam_x_reg};
            vy1_reg <= {s_point_y[47], s_point_y} - {cam_y_reg[47], cam_y_reg};
            vz1_reg <= {s_point_z[47], s_point_z} - {cam_z_reg[47], cam_z_reg};

            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            vz2_reg <= vz1_reg;
            m2_reg  <= (mag_xy1 > mag_z1) ? mag_xy1 : mag_z1;

            vx3_reg <= vx2_reg;
            vy3_reg <= vy2_reg;
            vz3_reg <= vz2_reg;
            s3_reg  <= shift_sel;

            vx4_reg <= sh_x[31:0];
            vy4_reg <= sh_y[31:0];
            vz4_reg <= sh_z[31:0];

            zx5_reg <= p_zx;
            zy5_reg <= p_zy;
            zz5_reg <= p_zz;
            xx5_reg <= p_xx;
            xy5_reg <= p_xy;
            yx5_reg <= p_yx;
            yy5_reg <= p_yy;
            yz5_reg <= p_yz;

            z6_reg <= {{2{zx5_reg[49]}}, zx5_reg} + {{2{zy5_reg[49]}}, zy5_reg}
                    + {{2{zz5_reg[49]}}, zz5_reg};
            x6_reg <= xx5_reg + xy5_reg;
            y6_reg <= yx5_reg + yy5_reg + yz5_reg;

            magx7_reg <= abs_x6[62:0];
            magy7_reg <= abs_y6[62:0];
            d7_reg    <= z_pos ? z6_reg[48:0] : 49'd1;

            plx8_reg <= p_lx;
            phx8_reg <= p_hx;
            ply8_reg <= p_ly;
            phy8_reg <= p_hy;
            d8_reg   <= d7_reg;

            px9_reg <= {phx8_reg, 32'b0} + {31'b0, plx8_reg};
            py9_reg <= {phy8_reg, 32'b0} + {31'b0, ply8_reg};
            d9_reg  <= d8_reg;

            prx_a_reg <= p_pix;
            pry_a_reg <= p_piy;

            m_x_reg      <= side_a_reg.behind ? sent_x : sat_x;
            m_y_reg      <= side_a_reg.behind ? sent_y : sat_y;
            m_behind_reg <= side_a_reg.behind;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_screen_x = m_x_reg;
    assign m_screen_y = m_y_reg;
    assign m_behind   = m_behind_reg;

endmodule
